// ===== rtl/core/ect_pkg.sv =====
// Package for the exposure countdown timer core.
// Holds widths, reset values, input and sound codes and the register map.
// No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps
`default_nettype none

package ect_pkg;

    // Timing base: ticks in one displayed second.
    localparam int TICKS_PER_SECOND = 100;

    // Field widths.
    localparam int SEC_W   = 7;
    localparam int SUB_W   = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int DIGIT_W = 4;
    localparam int BTN_W   = 2;

    // Divide-by-ten by reciprocal: (x * 205) >> 11 is exact for x below 1029.
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int PROD_W      = SEC_W + 8;

    // Reset values.
    localparam logic [SEC_W-1:0] RESET_SETPOINT    = SEC_W'(57);
    localparam logic [SEC_W-1:0] RESET_MAX_SECONDS = SEC_W'(100);

    // Item op codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Button codes.
    localparam logic [BTN_W-1:0] BTN_DEC   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_START = 2'd1;
    localparam logic [BTN_W-1:0] BTN_INC   = 2'd2;

    // Sound event codes.
    typedef enum logic [1:0] {
        SND_NONE  = 2'd0,
        SND_START = 2'd1,
        SND_ABORT = 2'd2,
        SND_ALARM = 2'd3
    } t_sound;

    // Register map.
    localparam int                  APB_ADDR_W      = 3;
    localparam int                  APB_DATA_W      = 32;
    localparam logic                REG_MAX_SECONDS = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/ect_if.sv =====
// Valid/ready channel interfaces for the exposure countdown timer core.
// ect_in_if carries input items, ect_out_if carries result items.
// Depends on ect_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ect_in_if
    import ect_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             op;
    logic [BTN_W-1:0] button;

    modport source (output valid, output op, output button, input ready);
    modport sink   (input valid, input op, input button, output ready);
endinterface

interface ect_out_if
    import ect_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] units_digit;
    logic               display_refresh;
    logic               lamp_on;
    logic [1:0]         sound_event;

    modport source (
        output valid, output tens_digit, output units_digit,
        output display_refresh, output lamp_on, output sound_event,
        input ready
    );
    modport sink (
        input valid, input tens_digit, input units_digit,
        input display_refresh, input lamp_on, input sound_event,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/ect_digit_split.sv =====
// Splits a whole-second count into tens and units display digits.
// Depends on ect_pkg for widths and the divide-by-ten reciprocal.
`timescale 1ns / 1ps
`default_nettype none

module ect_digit_split
    import ect_pkg::*;
(
    input  wire logic [SEC_W-1:0]   i_secs,
    output logic      [DIGIT_W-1:0] o_tens,
    output logic      [DIGIT_W-1:0] o_units
);

    logic [PROD_W-1:0] w_prod;
    logic [SEC_W-1:0]  w_tens_full;
    logic [SEC_W-1:0]  w_tens_x10;

    // tens = secs / 10 through a constant reciprocal
    assign w_prod      = PROD_W'(i_secs) * PROD_W'(DIV10_MUL);
    assign w_tens_full = SEC_W'(w_prod >> DIV10_SHIFT);
    assign w_tens_x10  = SEC_W'(w_tens_full * SEC_W'(10));

    assign o_tens  = DIGIT_W'(w_tens_full);
    assign o_units = DIGIT_W'(i_secs - w_tens_x10);

endmodule

`default_nettype wire

// ===== rtl/core/exposure_countdown_timer_core.sv =====
// Exposure countdown timer core: each accepted item's result goes to o_result in the
// next cycle; throughput one item per cycle while o_result is ready, set by the state
// update (setpoint, seconds, sub-second ticks, running) feeding the result register.
// Reset: i_rst_n, synchronous, active low; setpoint 57 s, count reloaded to 57 s,
// idle, max_seconds 100, result register empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module exposure_countdown_timer_core
    import ect_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ect_in_if.sink                     i_item,
    ect_out_if.source                  o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // ------------------------------------------------------------------
    // Configuration register. The word index is paddr[2]; byte lanes
    // in paddr[1:0] are ignored.
    // ------------------------------------------------------------------
    logic [SEC_W-1:0] r_max_seconds;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seconds <= RESET_MAX_SECONDS;
        end else if (w_cfg_wr && (paddr[2] == REG_MAX_SECONDS)) begin
            r_max_seconds <= pwdata[SEC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_SECONDS) ? APB_DATA_W'(r_max_seconds)
                                                  : '0;

    // ------------------------------------------------------------------
    // Timer state. The tick count is held as whole seconds plus a
    // sub-second tick count (0 .. TICKS_PER_SECOND-1), so the digits
    // come from the seconds alone. Count below zero never persists.
    // ------------------------------------------------------------------
    logic [SEC_W-1:0] r_setpoint, n_setpoint;
    logic [SEC_W-1:0] r_secs,     n_secs;
    logic [SUB_W-1:0] r_sub,      n_sub;
    logic             r_running,  n_running;
    logic             n_refresh;
    t_sound           n_sound;

    // Result register.
    logic               r_res_valid;
    logic [DIGIT_W-1:0] r_tens;
    logic [DIGIT_W-1:0] r_units;
    logic               r_refresh;
    logic               r_lamp;
    t_sound             r_sound;

    logic               w_accept;
    logic [DIGIT_W-1:0] w_tens;
    logic [DIGIT_W-1:0] w_units;

    // Take a new item whenever the result slot is free or drains this cycle.
    assign i_item.ready = !r_res_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    always_comb begin
        n_setpoint = r_setpoint;
        n_secs     = r_secs;
        n_sub      = r_sub;
        n_running  = r_running;
        n_refresh  = 1'b0;
        n_sound    = SND_NONE;

        if (i_item.op == OP_PRESS) begin
            if (r_running) begin
                // any press aborts the run and reloads
                n_running = 1'b0;
                n_secs    = r_setpoint;
                n_sub     = '0;
                n_refresh = 1'b1;
                n_sound   = SND_ABORT;
            end else begin
                unique case (i_item.button)
                    BTN_DEC: begin
                        if (r_setpoint != '0) begin
                            n_setpoint = r_setpoint - SEC_W'(1);
                        end
                        n_secs    = n_setpoint;
                        n_sub     = '0;
                        n_refresh = 1'b1;
                    end
                    BTN_INC: begin
                        // hold the setpoint if it is already at or above the limit
                        if (r_setpoint < r_max_seconds) begin
                            n_setpoint = r_setpoint + SEC_W'(1);
                        end
                        n_secs    = n_setpoint;
                        n_sub     = '0;
                        n_refresh = 1'b1;
                    end
                    BTN_START: begin
                        n_running = 1'b1;
                        n_sound   = SND_START;
                    end
                    default: begin
                        // unused button code while idle: drop it
                    end
                endcase
            end
        end else if (r_running) begin
            if (r_sub == '0) begin
                if (r_secs == '0) begin
                    // count passes below zero: lamp off, reload, alarm
                    n_running = 1'b0;
                    n_secs    = r_setpoint;
                    n_sub     = '0;
                    n_refresh = 1'b1;
                    n_sound   = SND_ALARM;
                end else begin
                    n_secs    = r_secs - SEC_W'(1);
                    n_sub     = SUB_W'(TICKS_PER_SECOND - 1);
                    n_refresh = (n_sub == '0);
                end
            end else begin
                n_sub     = r_sub - SUB_W'(1);
                n_refresh = (n_sub == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= RESET_SETPOINT;
            r_secs     <= RESET_SETPOINT;
            r_sub      <= '0;
            r_running  <= 1'b0;
        end else if (w_accept) begin
            r_setpoint <= n_setpoint;
            r_secs     <= n_secs;
            r_sub      <= n_sub;
            r_running  <= n_running;
        end
    end

    // Digits always follow the count after the step.
    ect_digit_split u_digits (
        .i_secs  (n_secs),
        .o_tens  (w_tens),
        .o_units (w_units)
    );

    // Result valid: set on accept, clear when taken without a new item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tens    <= w_tens;
            r_units   <= w_units;
            r_refresh <= n_refresh;
            r_lamp    <= n_running;
            r_sound   <= n_sound;
        end
    end

    assign o_result.valid           = r_res_valid;
    assign o_result.tens_digit      = r_tens;
    assign o_result.units_digit     = r_units;
    assign o_result.display_refresh = r_refresh;
    assign o_result.lamp_on         = r_lamp;
    assign o_result.sound_event     = r_sound;

`ifndef NO_ASSERTIONS
    // Sub-second count stays inside one second.
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub < SUB_W'(TICKS_PER_SECOND))
        else $error("sub-second count out of range");

    // A pending result shows the lamp state the timer currently holds.
    a_lamp_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_lamp == r_running))
        else $error("lamp output disagrees with running state");

    // A start beep comes with the lamp lit and no refresh.
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_sound == SND_START) |-> (r_lamp && !r_refresh))
        else $error("start result inconsistent");

    // A finish alarm reloads the count to the setpoint and refreshes.
    a_alarm_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_sound == SND_ALARM) |=>
            (r_secs == r_setpoint && r_sub == '0 && !r_running && r_refresh))
        else $error("alarm did not reload the count");
`endif

endmodule

`default_nettype wire
